FILE: hw/rtl/pec_pkg.sv
// Shared types, sizes and codes for the polygon edge crossing test.
package pec_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int COORD_BITS   = 16;

    localparam int IDX_W   = $clog2(MAX_VERTICES);
    localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [CROSS_W-1:0]    cross_t;
    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic [CNT_W-1:0]             cnt_t;

    typedef enum logic [1:0] {
        KIND_FIRST  = 2'd0,
        KIND_SECOND = 2'd1,
        KIND_EVAL   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t  kind;
        coord_t vx;
        coord_t vy;
    } item_t;

    typedef struct packed {
        logic hit;
        logic dropped;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_first;
        logic wr_second;
        idx_t wr_addr;
        logic issue;
        idx_t a0_idx;
        idx_t a1_idx;
        idx_t b0_idx;
        idx_t b1_idx;
        logic clear_hit;
    } dp_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic busy;
        logic hit;
    } dp_status_t;

endpackage

FILE: hw/rtl/pec_datapath.sv
// Vertex memories and the pipelined exact segment crossing test.
module pec_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  pec_pkg::item_t      item,
    input  pec_pkg::dp_cmd_t    cmd,
    output pec_pkg::dp_status_t status
);
    import pec_pkg::*;

    coord_t first_x_mem  [MAX_VERTICES];
    coord_t first_y_mem  [MAX_VERTICES];
    coord_t second_x_mem [MAX_VERTICES];
    coord_t second_y_mem [MAX_VERTICES];

    // Stage 1: endpoints read from the memories.
    coord_t a0x_reg, a0y_reg, a1x_reg, a1y_reg;
    coord_t b0x_reg, b0y_reg, b1x_reg, b1y_reg;
    // Stage 2: edge directions and the offset between edge starts.
    diff_t d1x_reg, d1y_reg, d2x_reg, d2y_reg, rx_reg, ry_reg;
    // Stage 3: the six products of the three cross products.
    prod_t den_p_reg, den_q_reg, tn_p_reg, tn_q_reg, un_p_reg, un_q_reg;
    // Stage 4: cross products.
    cross_t den_reg, tn_reg, un_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic hit_reg;
    logic hit_next;
    logic den_neg, den_zero, pair_hit;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_first)
        begin
            first_x_mem[cmd.wr_addr] <= item.vx;
            first_y_mem[cmd.wr_addr] <= item.vy;
        end
        if (cmd.wr_second)
        begin
            second_x_mem[cmd.wr_addr] <= item.vx;
            second_y_mem[cmd.wr_addr] <= item.vy;
        end
        a0x_reg <= first_x_mem[cmd.a0_idx];
        a0y_reg <= first_y_mem[cmd.a0_idx];
        a1x_reg <= first_x_mem[cmd.a1_idx];
        a1y_reg <= first_y_mem[cmd.a1_idx];
        b0x_reg <= second_x_mem[cmd.b0_idx];
        b0y_reg <= second_y_mem[cmd.b0_idx];
        b1x_reg <= second_x_mem[cmd.b1_idx];
        b1y_reg <= second_y_mem[cmd.b1_idx];
    end

    always_ff @(posedge clk)
    begin
        d1x_reg <= diff_t'(a1x_reg) - diff_t'(a0x_reg);
        d1y_reg <= diff_t'(a1y_reg) - diff_t'(a0y_reg);
        d2x_reg <= diff_t'(b1x_reg) - diff_t'(b0x_reg);
        d2y_reg <= diff_t'(b1y_reg) - diff_t'(b0y_reg);
        rx_reg  <= diff_t'(b0x_reg) - diff_t'(a0x_reg);
        ry_reg  <= diff_t'(b0y_reg) - diff_t'(a0y_reg);

        den_p_reg <= prod_t'(d1x_reg) * prod_t'(d2y_reg);
        den_q_reg <= prod_t'(d1y_reg) * prod_t'(d2x_reg);
        tn_p_reg  <= prod_t'(rx_reg) * prod_t'(d2y_reg);
        tn_q_reg  <= prod_t'(ry_reg) * prod_t'(d2x_reg);
        un_p_reg  <= prod_t'(rx_reg) * prod_t'(d1y_reg);
        un_q_reg  <= prod_t'(ry_reg) * prod_t'(d1x_reg);

        den_reg <= cross_t'(den_p_reg) - cross_t'(den_q_reg);
        tn_reg  <= cross_t'(tn_p_reg) - cross_t'(tn_q_reg);
        un_reg  <= cross_t'(un_p_reg) - cross_t'(un_q_reg);
    end

    // Both parameters must lie between zero and the denominator, on whichever
    // side of zero the denominator is. A zero denominator is never a crossing.
    always_comb
    begin
        den_neg  = den_reg[CROSS_W-1];
        den_zero = (den_reg == '0);
        if (den_zero)
        begin
            pair_hit = 1'b0;
        end
        else if (den_neg)
        begin
            pair_hit = (tn_reg[CROSS_W-1] || tn_reg == '0) && (tn_reg >= den_reg)
                    && (un_reg[CROSS_W-1] || un_reg == '0) && (un_reg >= den_reg);
        end
        else
        begin
            pair_hit = !tn_reg[CROSS_W-1] && (tn_reg <= den_reg)
                    && !un_reg[CROSS_W-1] && (un_reg <= den_reg);
        end
    end

    always_comb
    begin
        hit_next = hit_reg;
        if (cmd.clear_hit)
        begin
            hit_next = 1'b0;
        end
        else if (v4_reg && pair_hit)
        begin
            hit_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            v1_reg  <= cmd.issue;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            hit_reg <= hit_next;
        end
    end

    assign status.busy = v1_reg | v2_reg | v3_reg | v4_reg;
    assign status.hit  = hit_reg;

endmodule

FILE: hw/rtl/pec_ctrl.sv
// Controller: vertex counts, edge pair walk, result register.
module pec_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  pec_pkg::item_t      item,
    input  logic                item_valid,
    output logic                item_ready,
    output pec_pkg::result_t    result,
    output logic                result_valid,
    input  logic                result_ready,
    output pec_pkg::dp_cmd_t    cmd,
    input  pec_pkg::dp_status_t status
);
    import pec_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_WALK   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_REPORT = 4'b1000
    } state_t;

    state_t  state_reg, state_next;
    cnt_t    first_count_reg, first_count_next;
    cnt_t    second_count_reg, second_count_next;
    logic    overflow_reg, overflow_next;
    idx_t    i_reg, i_next;
    idx_t    j_reg, j_next;
    logic    result_valid_reg, result_valid_next;
    result_t result_reg, result_next;
    logic    accept;
    logic    i_last, j_last;

    assign item_ready   = (state_reg == ST_IDLE);
    assign accept       = item_valid && item_ready;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    assign i_last = (cnt_t'(i_reg) + cnt_t'(1)) == first_count_reg;
    assign j_last = (cnt_t'(j_reg) + cnt_t'(1)) == second_count_reg;

    always_comb
    begin
        state_next        = state_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        overflow_next     = overflow_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        cmd               = '0;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.kind)
                        KIND_FIRST:
                        begin
                            if (first_count_reg < cnt_t'(MAX_VERTICES))
                            begin
                                cmd.wr_first     = 1'b1;
                                cmd.wr_addr      = first_count_reg[IDX_W-1:0];
                                first_count_next = first_count_reg + cnt_t'(1);
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        KIND_SECOND:
                        begin
                            if (second_count_reg < cnt_t'(MAX_VERTICES))
                            begin
                                cmd.wr_second     = 1'b1;
                                cmd.wr_addr       = second_count_reg[IDX_W-1:0];
                                second_count_next = second_count_reg + cnt_t'(1);
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        KIND_EVAL:
                        begin
                            cmd.clear_hit = 1'b1;
                            i_next        = '0;
                            j_next        = '0;
                            if (first_count_reg != '0 && second_count_reg != '0)
                            begin
                                state_next = ST_WALK;
                            end
                            else
                            begin
                                state_next = ST_DRAIN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                cmd.issue  = 1'b1;
                cmd.a0_idx = i_reg;
                cmd.a1_idx = i_last ? '0 : i_reg + idx_t'(1);
                cmd.b0_idx = j_reg;
                cmd.b1_idx = j_last ? '0 : j_reg + idx_t'(1);
                if (j_last)
                begin
                    j_next = '0;
                    if (i_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        i_next = i_reg + idx_t'(1);
                    end
                end
                else
                begin
                    j_next = j_reg + idx_t'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!status.busy)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.hit     = status.hit;
                    result_next.dropped = overflow_reg;
                    result_valid_next   = 1'b1;
                    first_count_next    = '0;
                    second_count_next   = '0;
                    overflow_next       = 1'b0;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            overflow_reg     <= 1'b0;
            i_reg            <= '0;
            j_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            overflow_reg     <= overflow_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // The walk only addresses loaded vertices.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (cnt_t'(i_reg) < first_count_reg) && (cnt_t'(j_reg) < second_count_reg))
        else $error("edge pair walk outside loaded vertices");

    // Vertex counts never pass the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        (first_count_reg <= cnt_t'(MAX_VERTICES)) && (second_count_reg <= cnt_t'(MAX_VERTICES)))
        else $error("vertex count beyond capacity");

    // An accepted evaluate beat always leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.kind == KIND_EVAL) |=> (state_reg != ST_IDLE))
        else $error("evaluate beat did not start a walk");

    // A result is only produced from the report state, with the pipeline empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_REPORT) && !$past(status.busy))
        else $error("result produced outside report");

endmodule

FILE: hw/rtl/polygon_edge_crossing_test.sv
// Top level of the polygon edge crossing test.
//
// The item channel (item_valid, item_ready, item) carries one beat per vertex
// or command. Kind first or second appends the vertex to that polygon; a
// vertex beyond the capacity of MAX_VERTICES is dropped and noted.
// Kind evaluate tests every edge of the first polygon against every edge of
// the second with exact integer cross products, ends included, and then
// clears both polygons. Kind three is taken and ignored.
// The result channel (result_valid, result_ready, result) carries one beat
// per evaluate: hit, and dropped for vertices lost since the last evaluate.
// An evaluate with n and m vertices walks n*m edge pairs, one per cycle,
// through a five-stage read, subtract, multiply, subtract and compare
// pipeline; the result beat follows once the pipeline has drained, and
// the walk is skipped when either polygon is empty. The item channel is
// held off meanwhile.
// If the receiver stalls, loads are still taken while a result waits; a
// following evaluate finishes its walk and then waits for the result
// register to free up. Reset empties both polygons, clears the dropped flag
// and drops any waiting result beat; no clearing pass over the memories is
// needed.
module polygon_edge_crossing_test (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  pec_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output pec_pkg::result_t result
);
    import pec_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller owns the counts, the pair walk and the result beat.
    pec_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd),
        .status       (status)
    );

    // The datapath holds the vertex memories and the crossing pipeline.
    pec_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status)
    );

endmodule
